[hdl/fmpq_pkg.sv]
package fmpq_pkg;

  // Field widths are fixed by the word formats on the ports.
  localparam int unsigned PayloadWidth      = 32;
  localparam int unsigned PriorityWidth     = 16;
  localparam int unsigned EntryCountWidth   = 5;
  localparam int unsigned QueueDepthDefault = 16;

  // Index and count fields between the sequencer and the cells are sized for the
  // largest supported depth of 256 entries.
  localparam int unsigned IdxMaxW = 8;
  localparam int unsigned CntMaxW = 9;

  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_POP_OLDEST = 2'd1,
    OP_POP_MIN    = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [PayloadWidth-1:0]  payload;
    logic [PriorityWidth-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [PayloadWidth-1:0]    popped_payload;
    logic [PriorityWidth-1:0]   popped_priority;
    logic                       is_empty;
    logic [EntryCountWidth-1:0] entry_count;
    logic [PayloadWidth-1:0]    head_payload;
    logic [PayloadWidth-1:0]    tail_payload;
  } out_word_t;

  // Search token that walks the chain one cell per cycle.
  typedef struct packed {
    logic                     vld;
    logic                     seen;
    logic [IdxMaxW-1:0]       idx;
    logic [PriorityWidth-1:0] best_pri;
    logic [PayloadWidth-1:0]  best_pay;
    logic [PayloadWidth-1:0]  last_pay;
    logic [PayloadWidth-1:0]  prev_pay;
  } token_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     push;
    logic                     shift;
    logic [IdxMaxW-1:0]       idx_best;
    logic [CntMaxW-1:0]       count;
    logic [PayloadWidth-1:0]  pay;
    logic [PriorityWidth-1:0] pri;
  } cell_ctrl_t;

endpackage

[hdl/fifo_with_min_priority_pop_core.sv]
// Bounded queue of payload and priority entries kept in arrival order, with a
// pop-oldest and a pop-smallest-priority operation (ties go to the oldest).
// Input channel: in_valid_i / in_ready_o carry one command word (opcode,
// payload, priority). Output channel: out_valid_o / out_ready_i carry one
// result word per command: status, the removed entry, the fill count and the
// head and tail payloads after the command.
// Push, pop-oldest, clear and any rejected command are handled when accepted;
// the result word is registered and shows in the cycle after acceptance. Pop-min
// sends a search token through the chain of cells, one cell per cycle, and the
// result is registered once the token has left the last cell, so the length of
// the cell chain sets how long it takes. One command is in progress at a time.
// The output register parts the two sides: a new command is taken while a
// result still waits, as long as that result leaves in the same cycle or the
// register is empty. When the receiver stalls, the result holds and no new
// command is accepted.
// Reset empties the queue and drops any pending result. Stored entries are not
// cleared; only the fill count decides which cells hold data.
module fifo_with_min_priority_pop_core #(
  parameter int unsigned QueueDepth = fmpq_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmpq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmpq_pkg::out_word_t out_word_o
);
  import fmpq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Fill count and a copy of the newest payload.
  logic [CntW-1:0]         count_q, count_d;
  logic [PayloadWidth-1:0] tail_q, tail_d;
  state_e                  state_q, state_d;
  out_word_t               out_q, out_d;
  logic                    out_vld_q, out_vld_d;

  cell_ctrl_t ctrl;
  token_t     tok [QueueDepth+1];
  logic [PayloadWidth-1:0]  cell_pay [QueueDepth];
  logic [PriorityWidth-1:0] cell_pri [QueueDepth];

  logic            in_acc;
  op_e             op;
  logic [CntW-1:0] cnt_m1;
  token_t          tok_last;

  // Builds a result word; head and tail read as zero when the queue is empty.
  function automatic out_word_t mk_out(
    input status_e                  st,
    input logic [PayloadWidth-1:0]  ppay,
    input logic [PriorityWidth-1:0] ppri,
    input logic [CntW-1:0]          cnt,
    input logic [PayloadWidth-1:0]  head,
    input logic [PayloadWidth-1:0]  tail
  );
    out_word_t w;
    w.status          = st;
    w.popped_payload  = ppay;
    w.popped_priority = ppri;
    w.is_empty        = (cnt == '0);
    w.entry_count     = EntryCountWidth'(cnt);
    w.head_payload    = (cnt == '0) ? '0 : head;
    w.tail_payload    = (cnt == '0) ? '0 : tail;
    return w;
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && (!out_vld_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op         = op_e'(in_word_i.opcode);
  assign cnt_m1     = count_q - CntW'(1);
  assign tok_last   = tok[QueueDepth];

  // A pop-min on a non-empty queue launches the search token into cell zero.
  assign tok[0] = '{vld: in_acc && (op == OP_POP_MIN) && (count_q != '0), default: '0};

  always_comb begin
    ctrl          = '0;
    ctrl.count    = CntMaxW'(count_q);
    ctrl.pay      = in_word_i.payload;
    ctrl.pri      = in_word_i.priority_req;
    count_d       = count_q;
    tail_d        = tail_q;
    state_d       = state_q;
    out_d         = out_q;
    out_vld_d     = out_vld_q && !out_ready_i;

    if (state_q == S_IDLE) begin
      if (in_acc) begin
        case (op)
          OP_PUSH: begin
            out_vld_d = 1'b1;
            if (count_q == CntW'(QueueDepth)) begin
              out_d = mk_out(ST_FULL, '0, '0, count_q, cell_pay[0], tail_q);
            end else begin
              ctrl.push = 1'b1;
              count_d   = count_q + CntW'(1);
              tail_d    = in_word_i.payload;
              out_d     = mk_out(ST_OK, '0, '0, count_q + CntW'(1),
                                 (count_q == '0) ? in_word_i.payload : cell_pay[0],
                                 in_word_i.payload);
            end
          end
          OP_POP_OLDEST, OP_POP_MIN: begin
            if (count_q == '0) begin
              out_vld_d = 1'b1;
              out_d     = mk_out(ST_EMPTY, '0, '0, '0, '0, '0);
            end else if (op == OP_POP_OLDEST) begin
              out_vld_d     = 1'b1;
              ctrl.shift    = 1'b1;
              ctrl.idx_best = '0;
              count_d       = cnt_m1;
              out_d         = mk_out(ST_OK, cell_pay[0], cell_pri[0], cnt_m1,
                                     cell_pay[1], tail_q);
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_CLEAR: begin
            out_vld_d = 1'b1;
            count_d   = '0;
            out_d     = mk_out(ST_OK, '0, '0, '0, '0, '0);
          end
          default: begin
            out_vld_d = 1'b1;
            count_d   = '0;
            out_d     = mk_out(ST_OK, '0, '0, '0, '0, '0);
          end
        endcase
      end
    end else begin
      // The token has passed every cell: remove the winner and close the gap.
      if (tok_last.vld) begin
        state_d       = S_IDLE;
        out_vld_d     = 1'b1;
        ctrl.shift    = 1'b1;
        ctrl.idx_best = tok_last.idx;
        count_d       = cnt_m1;
        if (CntMaxW'(tok_last.idx) == CntMaxW'(cnt_m1)) begin
          tail_d = tok_last.prev_pay;
        end else begin
          tail_d = tok_last.last_pay;
        end
        out_d = mk_out(ST_OK, tok_last.best_pay, tok_last.best_pri, cnt_m1,
                       (tok_last.idx == '0) ? cell_pay[1] : cell_pay[0], tail_d);
      end
    end
  end

  for (genvar k = 0; k < QueueDepth; k++) begin : g_cell
    logic [PayloadWidth-1:0]  nxt_pay;
    logic [PriorityWidth-1:0] nxt_pri;
    if (k == QueueDepth - 1) begin : g_end
      assign nxt_pay = cell_pay[k];
      assign nxt_pri = cell_pri[k];
    end else begin : g_mid
      assign nxt_pay = cell_pay[k+1];
      assign nxt_pri = cell_pri[k+1];
    end
    fmpq_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .nxt_pay_i (nxt_pay),
      .nxt_pri_i (nxt_pri),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .pay_o     (cell_pay[k]),
      .pri_o     (cell_pri[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[hdl/fmpq_cell.sv]
module fmpq_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fmpq_pkg::cell_ctrl_t              ctrl_i,
  input  logic [fmpq_pkg::PayloadWidth-1:0]  nxt_pay_i,
  input  logic [fmpq_pkg::PriorityWidth-1:0] nxt_pri_i,
  input  fmpq_pkg::token_t                  tok_i,
  output fmpq_pkg::token_t                  tok_o,
  output logic [fmpq_pkg::PayloadWidth-1:0]  pay_o,
  output logic [fmpq_pkg::PriorityWidth-1:0] pri_o
);
  import fmpq_pkg::*;

  logic [PayloadWidth-1:0]  pay_q, pay_d;
  logic [PriorityWidth-1:0] pri_q, pri_d;
  token_t                   tok_q, tok_d;
  logic                     occ;

  // The cell holds an entry when its position lies below the fill count.
  assign occ = (CntMaxW'(CellIdx) < ctrl_i.count);

  always_comb begin
    pay_d = pay_q;
    pri_d = pri_q;
    if (ctrl_i.push && (CntMaxW'(CellIdx) == ctrl_i.count)) begin
      pay_d = ctrl_i.pay;
      pri_d = ctrl_i.pri;
    end else if (ctrl_i.shift && (IdxMaxW'(CellIdx) >= ctrl_i.idx_best)) begin
      pay_d = nxt_pay_i;
      pri_d = nxt_pri_i;
    end
  end

  // Strict less-than keeps the oldest entry on a tie.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && occ) begin
      if (!tok_i.seen || (pri_q < tok_i.best_pri)) begin
        tok_d.best_pri = pri_q;
        tok_d.best_pay = pay_q;
        tok_d.idx      = IdxMaxW'(CellIdx);
      end
      tok_d.seen     = 1'b1;
      tok_d.prev_pay = tok_i.last_pay;
      tok_d.last_pay = pay_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    pri_q <= pri_d;
  end

  assign tok_o = tok_q;
  assign pay_o = pay_q;
  assign pri_o = pri_q;

endmodule
